### rtl/escape_coded_sample_player_assert.svh
// assertion macros for the escape coded sample player
`ifndef ESCAPE_CODED_SAMPLE_PLAYER_ASSERT_SVH
`define ESCAPE_CODED_SAMPLE_PLAYER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ESCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escp assertion failed");

// next-cycle implication, checked out of reset
`define ESCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escp assertion failed");

`endif

### rtl/escp_pkg.sv
// shared types and constants for the escape coded sample player
package escp_pkg;

  // action codes on the input channel
  localparam logic [1:0] ACT_CMD  = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;

  localparam logic [7:0]  ESCAPE_CODE  = 8'h80;
  localparam logic [15:0] SILENCE      = 16'h8000;
  localparam logic [2:0]  GROUP_LEN    = 3'd5;
  localparam logic [2:0]  CMD_KEEP     = 3'd3;
  localparam logic [3:0]  START_SHIFT  = 4'd8;
  localparam logic [1:0]  ESCAPE_LIMIT = 2'd3;
  localparam int          START_W      = 20;

  // item queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_TICK,
    OP_LOAD,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] load_address;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } front_status_t;

  typedef struct packed {
    logic busy;
    logic active;
  } back_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_FETCH
  } back_state_t;

endpackage

### rtl/escp_front.sv
// front end: takes input beats, decodes the action and queues the item
module escp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_data,
  input  logic [15:0]           in_load_address,
  output logic                  q_valid,
  output escp_pkg::item_t       q_item,
  input  logic                  q_pop,
  output escp_pkg::front_status_t status
);
  import escp_pkg::*;

  item_t             entry_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  item_t             item_in;

  assign in_stall = (count_r == QCNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    item_in.data         = in_data;
    item_in.load_address = in_load_address;
    case (in_action)
      ACT_CMD:  item_in.op = OP_CMD;
      ACT_TICK: item_in.op = OP_TICK;
      ACT_LOAD: item_in.op = OP_LOAD;
      default:  item_in.op = OP_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item_in;
    end
  end

  assign q_valid      = (count_r != '0);
  assign q_item       = entry_r[rd_ptr_r];
  assign status.count = count_r;

endmodule

### rtl/escp_back.sv
// back end: command assembly, sample store and escape-aware playback
module escp_back #(
  parameter int ADDR_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  escp_pkg::item_t        q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_dac_value,
  output logic                   out_playing,
  output escp_pkg::back_status_t status
);
  import escp_pkg::*;

  localparam int LA_W = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam logic [ADDR_BITS-1:0] ADDR_MASK = {ADDR_BITS{1'b1}};

  logic [7:0] mem [2**ADDR_BITS];

  back_state_t          state_r, state_nxt;
  logic [7:0]           cmd_r [3];
  logic [7:0]           cmd_nxt [3];
  logic [2:0]           byte_cnt_r, byte_cnt_nxt;
  logic [ADDR_BITS-1:0] play_r, play_nxt;
  logic                 active_r, active_nxt;
  logic [3:0]           shift_r, shift_nxt;
  logic [15:0]          dac_r, dac_nxt;
  logic [1:0]           esc_r, esc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [15:0]          out_dac_r;
  logic                 out_play_r;
  logic [7:0]           rd_data_r;

  logic                 slot_free, rd_en, wr_en, done;
  logic                 is_esc, stop, more;
  logic [1:0]           esc_new;
  logic [2:0]           cnt_inc;
  logic [START_W-1:0]   start;
  logic [LA_W-1:0]      la_ext;
  logic [ADDR_BITS-1:0] wr_addr;

  function automatic logic [15:0] dac_of(input logic [7:0] s, input logic [3:0] sh);
    logic [15:0] ext;
    ext    = {{8{s[7]}}, s};
    dac_of = SILENCE - (ext << sh);
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == BK_IDLE) && q_valid && slot_free;

  assign is_esc  = (rd_data_r == ESCAPE_CODE);
  assign esc_new = esc_r + 2'd1;
  assign stop    = is_esc && ((play_r == ADDR_MASK) || (esc_new == ESCAPE_LIMIT));
  assign more    = is_esc && !stop;

  assign cnt_inc = byte_cnt_r + 3'd1;
  assign start   = (START_W'(cmd_r[0]) << 12) | (START_W'(cmd_r[1]) << 4)
                 | START_W'(cmd_r[2][7:4]);
  assign la_ext  = LA_W'(q_item.load_address);
  assign wr_addr = la_ext[ADDR_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_pop && (q_item.op == OP_TICK) && active_r) state_nxt = BK_FETCH;
      end
      BK_FETCH: begin
        if (!more) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt      = cmd_r;
    byte_cnt_nxt = byte_cnt_r;
    play_nxt     = play_r;
    active_nxt   = active_r;
    shift_nxt    = shift_r;
    dac_nxt      = dac_r;
    esc_nxt      = esc_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    done         = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          done = 1'b1;
          case (q_item.op)
            OP_CMD: begin
              if (byte_cnt_r < CMD_KEEP) cmd_nxt[byte_cnt_r[1:0]] = q_item.data;
              if (cnt_inc == GROUP_LEN) begin
                play_nxt     = start[ADDR_BITS-1:0];
                byte_cnt_nxt = '0;
                if (start != '0) begin
                  active_nxt = 1'b1;
                  shift_nxt  = START_SHIFT;
                end
              end else begin
                byte_cnt_nxt = cnt_inc;
              end
            end
            OP_TICK: begin
              if (active_r) begin
                rd_en    = 1'b1;
                play_nxt = play_r + 1'b1;
                esc_nxt  = '0;
                done     = 1'b0;
              end
            end
            OP_LOAD: wr_en = 1'b1;
            default: ;
          endcase
        end
      end
      BK_FETCH: begin
        if (is_esc) begin
          // only the first escape of a run lowers the shift
          if ((esc_r == '0) && (shift_r != '0)) shift_nxt = shift_r - 4'd1;
          if (stop) begin
            active_nxt = 1'b0;
            dac_nxt    = SILENCE;
            done       = 1'b1;
          end else begin
            rd_en    = 1'b1;
            play_nxt = play_r + 1'b1;
            esc_nxt  = esc_new;
          end
        end else begin
          dac_nxt = dac_of(rd_data_r, shift_r);
          done    = 1'b1;
        end
      end
      default: ;
    endcase
    out_valid_nxt = done || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cmd_r       <= '{default: '0};
      byte_cnt_r  <= '0;
      play_r      <= '0;
      active_r    <= 1'b0;
      shift_r     <= '0;
      dac_r       <= SILENCE;
      esc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      play_r      <= play_nxt;
      active_r    <= active_nxt;
      shift_r     <= shift_nxt;
      dac_r       <= dac_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_dac_r  <= dac_nxt;
      out_play_r <= active_nxt;
    end
  end

  // sample store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= q_item.data;
    if (rd_en) rd_data_r <= mem[play_r];
  end

  assign out_valid     = out_valid_r;
  assign out_dac_value = out_dac_r;
  assign out_playing   = out_play_r;
  assign status.busy   = (state_r == BK_FETCH);
  assign status.active = active_r;

endmodule

### rtl/escape_coded_sample_player.sv
// escape coded sample player: command byte collection, sample store, playback
// path: a command, load or idle tick result passes the item queue and the output
// register, a playing tick result also one to three registered store reads
// rate: one beat per cycle unless stalled, a playing tick holds the back end busy
// reset (rst_n low, synchronous) empties the queue, stops playback and sets the
// dac word to 0x8000, the sample store keeps its contents
module escape_coded_sample_player #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_load_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_dac_value,
  output logic        out_playing
);
  import escp_pkg::*;

  logic          q_valid;
  item_t         q_item;
  logic          q_pop;
  front_status_t fe_st;
  back_status_t  bk_st;

  escp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data         (in_data),
    .in_load_address (in_load_address),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .status          (fe_st)
  );

  escp_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dac_value (out_dac_value),
    .out_playing   (out_playing),
    .status        (bk_st)
  );

`include "escape_coded_sample_player_assert.svh"

  `ESCP_ASSERT_IMP(a_fetch_only_playing, bk_st.busy, bk_st.active)
  `ESCP_ASSERT_IMP(a_no_pop_in_fetch, bk_st.busy, !q_pop)
  `ESCP_ASSERT_IMP(a_pop_nonempty, q_pop, fe_st.count != '0)
  `ESCP_ASSERT_NEXT(a_slot_drains, out_valid && !out_stall && !q_pop && !bk_st.busy, !out_valid)

endmodule

### test/escape_coded_sample_player_checker.sv
// checker for the escape coded sample player: predicts every result beat and compares
module escape_coded_sample_player_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_load_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_dac_value,
  input  logic        out_playing,
  output int          mismatches,
  output int          outstanding,
  output int          stops
);
  timeunit 1ns;
  timeprecision 1ps;
  import escp_pkg::*;

  localparam int          STORE_DEPTH = 65536;
  localparam logic [15:0] LAST_ADDR   = 16'hffff;
  localparam int          SHOW_MAX    = 10;

  typedef struct packed {
    logic [15:0] dac_value;
    logic        playing;
  } player_out_t;

  logic [7:0]  sample_mem [STORE_DEPTH];
  logic [7:0]  cmd_hold [3];
  logic [2:0]  cmd_count = '0;
  logic [15:0] play_ptr = '0;
  logic        running = 1'b0;
  logic [3:0]  shift = '0;
  logic [15:0] dac_word = SILENCE;
  player_out_t expected_q [$];
  int          err_cnt = 0;
  int          result_cnt = 0;
  int          stop_cnt = 0;

  task automatic take_cmd_byte(input logic [7:0] b);
    logic [19:0] start;
    if (cmd_count < CMD_KEEP) cmd_hold[cmd_count] = b;
    cmd_count = cmd_count + 3'd1;
    if (cmd_count == GROUP_LEN) begin
      start = {cmd_hold[0], 12'h000} | {8'h00, cmd_hold[1], 4'h0}
            | {16'h0000, cmd_hold[2][7:4]};
      play_ptr = start[15:0];
      // nonzero test is on the full start, before the wrap
      if (start != '0) begin
        running = 1'b1;
        shift = START_SHIFT;
      end
      cmd_count = '0;
    end
  endtask

  task automatic play_tick();
    logic [7:0]  s;
    logic [1:0]  escapes;
    logic [15:0] ext;
    if (!running) return;
    escapes = '0;
    s = sample_mem[play_ptr];
    play_ptr = play_ptr + 16'd1;
    while (s == ESCAPE_CODE) begin
      escapes = escapes + 2'd1;
      // only the first escape of a run lowers the shift
      if (escapes == 2'd1 && shift != '0) shift = shift - 4'd1;
      if (play_ptr == LAST_ADDR || escapes == ESCAPE_LIMIT) begin
        running = 1'b0;
        s = '0;
        stop_cnt++;
      end else begin
        s = sample_mem[play_ptr];
        play_ptr = play_ptr + 16'd1;
      end
    end
    ext = {{8{s[7]}}, s};
    dac_word = SILENCE - (ext << shift);
  endtask

  always @(posedge clk) begin : watch
    player_out_t want;
    if (!rst_n) begin
      foreach (cmd_hold[i]) cmd_hold[i] = '0;
      cmd_count = '0;
      play_ptr = '0;
      running = 1'b0;
      shift = '0;
      dac_word = SILENCE;
      expected_q.delete();
    end else begin
      // results first: a beat taken at this edge cannot already be on the output
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("result %0d with nothing expected: dac_value %h playing %b",
                     result_cnt, out_dac_value, out_playing);
        end else begin
          want = expected_q.pop_front();
          if (out_dac_value !== want.dac_value || out_playing !== want.playing) begin
            err_cnt++;
            if (err_cnt <= SHOW_MAX)
              $display("result %0d: dac_value exp %h got %h, playing exp %b got %b",
                       result_cnt, want.dac_value, out_dac_value,
                       want.playing, out_playing);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_CMD:  take_cmd_byte(in_data);
          ACT_TICK: play_tick();
          ACT_LOAD: sample_mem[in_load_address] = in_data;
          default: ;
        endcase
        expected_q.push_back('{dac_value: dac_word, playing: running});
      end
    end
    mismatches <= err_cnt;
    outstanding <= expected_q.size();
    stops <= stop_cnt;
  end

endmodule

### test/escape_coded_sample_player_tb.sv
// testbench top for the escape coded sample player: stimulus, idling and verdict
module escape_coded_sample_player_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import escp_pkg::*;

  localparam logic [1:0]  ACT_UNKNOWN = 2'd3;
  localparam int          STORE_DEPTH = 65536;
  localparam logic [15:0] LAST_ADDR   = 16'hffff;
  localparam int          PHASE_BEATS = 150;
  localparam int          SETTLE      = 12;
  localparam int          CYCLE_LIMIT = 500_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_CMD;
  logic [7:0]  in_data = '0;
  logic [15:0] in_load_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_dac_value;
  logic        out_playing;

  // stimulus-side view of the store and the play pointer
  logic [7:0]  shadow_mem [STORE_DEPTH];
  bit          written [STORE_DEPTH];
  logic [7:0]  shadow_cmd [3];
  logic [15:0] shadow_ptr = '0;
  bit          shadow_running = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int cmd_phase = 0;
  int tally = 0;
  int n_cmd = 0;
  int n_tick = 0;
  int n_load = 0;
  int n_fill = 0;
  int n_other = 0;
  int cycle_count = 0;
  int mismatches;
  int outstanding;
  int stops;

  escape_coded_sample_player uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_data(in_data),
    .in_load_address(in_load_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_dac_value(out_dac_value),
    .out_playing(out_playing)
  );

  escape_coded_sample_player_checker chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_data(in_data),
    .in_load_address(in_load_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_dac_value(out_dac_value),
    .out_playing(out_playing),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .stops(stops)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // moves the stimulus-side play pointer the way a taken tick does
  task automatic follow_tick();
    logic [7:0] s;
    int         esc;
    if (!shadow_running) return;
    esc = 0;
    s = shadow_mem[shadow_ptr];
    shadow_ptr = shadow_ptr + 16'd1;
    while (s == ESCAPE_CODE) begin
      esc++;
      if (shadow_ptr == LAST_ADDR || esc == int'(ESCAPE_LIMIT)) begin
        shadow_running = 1'b0;
        s = '0;
      end else begin
        s = shadow_mem[shadow_ptr];
        shadow_ptr = shadow_ptr + 16'd1;
      end
    end
  endtask

  task automatic drive_beat(input logic [1:0] act, input logic [7:0] dat,
                            input logic [15:0] addr);
    logic [19:0] start;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_data <= dat;
    in_load_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (act)
      ACT_CMD: begin
        n_cmd++;
        if (cmd_phase < CMD_KEEP) shadow_cmd[cmd_phase] = dat;
        if (cmd_phase == GROUP_LEN - 1) begin
          start = {shadow_cmd[0], 12'h000} | {8'h00, shadow_cmd[1], 4'h0}
                | {16'h0000, shadow_cmd[2][7:4]};
          shadow_ptr = start[15:0];
          if (start != '0) shadow_running = 1'b1;
        end
        cmd_phase = (cmd_phase + 1) % GROUP_LEN;
      end
      ACT_TICK: begin
        n_tick++;
        follow_tick();
      end
      ACT_LOAD: begin
        n_load++;
        shadow_mem[addr] = dat;
        written[addr] = 1'b1;
      end
      default:  n_other++;
    endcase
    if (act != ACT_UNKNOWN) tally++;
  endtask

  // loads every entry that the next tick would read before it was ever written
  task automatic prime_tick();
    logic [15:0] p;
    int          esc;
    bit          more;
    if (!shadow_running) return;
    p = shadow_ptr;
    esc = 0;
    more = 1'b1;
    while (more) begin
      if (!written[p]) begin
        n_fill++;
        drive_beat(ACT_LOAD, 8'($urandom), p);
      end
      more = 1'b0;
      if (shadow_mem[p] == ESCAPE_CODE) begin
        esc++;
        p = p + 16'd1;
        more = (p != LAST_ADDR) && (esc < int'(ESCAPE_LIMIT));
      end
    end
  endtask

  task automatic send_beat(input logic [1:0] act, input logic [7:0] dat,
                           input logic [15:0] addr);
    if (act == ACT_TICK) prime_tick();
    drive_beat(act, dat, addr);
  endtask

  // pads a broken group to its end, then sends a full group of five bytes
  task automatic send_group(input logic [7:0] b0, b1, b2);
    while (cmd_phase != 0) send_beat(ACT_CMD, 8'($urandom), 16'($urandom));
    send_beat(ACT_CMD, b0, 16'($urandom));
    send_beat(ACT_CMD, b1, 16'($urandom));
    send_beat(ACT_CMD, b2, 16'($urandom));
    repeat (2) send_beat(ACT_CMD, 8'($urandom), 16'($urandom));
  endtask

  // upper nibble of the first byte only lands above the store and is dropped
  task automatic play_from(input logic [15:0] addr);
    send_group({4'($urandom), addr[15:12]}, addr[11:4], {addr[3:0], 4'($urandom)});
  endtask

  task automatic load_run(input logic [15:0] addr, input int count, input int esc_pct);
    for (int i = 0; i < count; i++)
      send_beat(ACT_LOAD, ($urandom_range(99) < esc_pct) ? ESCAPE_CODE : 8'($urandom),
                addr + 16'(i));
  endtask

  task automatic random_phase(input int idle, input int stall);
    int          phase_end;
    int          pick;
    int          count;
    logic [15:0] base;
    idle_pct = idle;
    stall_pct <= stall;
    phase_end = tally + PHASE_BEATS;
    while (tally < phase_end) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        case ($urandom_range(9))
          0:       base = 16'hfff0 | 16'($urandom_range(15));
          1:       base = 16'($urandom_range(15));
          default: base = 16'($urandom);
        endcase
        count = $urandom_range(1, 24);
        load_run(base, count, $urandom_range(5, 60));
        play_from(base);
        repeat ($urandom_range(1, 20)) begin
          case ($urandom_range(19))
            // zero start: a running playback carries on from address zero
            0:       send_group(8'h00, 8'h00, {4'h0, 4'($urandom)});
            1:       send_beat(ACT_LOAD, 8'($urandom), 16'($urandom));
            default: send_beat(ACT_TICK, 8'($urandom), 16'($urandom));
          endcase
        end
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) send_beat(ACT_CMD, 8'($urandom), 16'($urandom));
        repeat ($urandom_range(0, 3)) send_beat(ACT_TICK, 8'($urandom), 16'($urandom));
      end else begin
        send_beat(2'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // tick while idle, unknown action, zero start with nothing running
    send_beat(ACT_TICK, 8'hff, 16'hffff);
    send_beat(ACT_UNKNOWN, 8'hff, 16'hffff);
    send_group(8'h00, 8'h00, 8'h0f);
    // largest sample, then an escape pair that ends right before the last address
    send_beat(ACT_LOAD, 8'h7f, 16'hfffc);
    send_beat(ACT_LOAD, ESCAPE_CODE, 16'hfffd);
    send_beat(ACT_LOAD, ESCAPE_CODE, 16'hfffe);
    send_group(8'h0f, 8'hff, 8'hc0);
    repeat (2) send_beat(ACT_TICK, 8'h00, 16'h0000);
    // start above the store wraps to zero, three escapes stop it
    for (int a = 0; a < 3; a++) send_beat(ACT_LOAD, ESCAPE_CODE, 16'(a));
    send_group(8'h10, 8'h00, 8'h00);
    send_beat(ACT_TICK, 8'h00, 16'h0000);

    random_phase(0, 0);
    random_phase(70, 0);
    random_phase(0, 70);
    random_phase(27, 27);

    in_valid <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d cmd bytes, %0d ticks, %0d loads (%0d ahead of ticks), %0d other",
             n_cmd, n_tick, n_load, n_fill, n_other);
    $display("%0d playbacks stopped, idling phases none/sender/receiver/both", stops);
    if (mismatches == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
